>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser package
// Types, codes and constants shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfp_pkg;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER     = 2'd0,
        KIND_PAYLOAD    = 2'd1,
        KIND_ERROR      = 2'd2,
        KIND_INCOMPLETE = 2'd3
    } t_kind;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN_CODE_16 = 7'h7E;
    localparam logic [6:0] LEN_CODE_64 = 7'h7F;

    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

    typedef struct packed {
        t_kind       kind;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] body_length;
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic        short_buffer;
    } t_result;

    function automatic logic opcode_valid(input logic [3:0] op);
        return op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
    endfunction

endpackage

`default_nettype wire

>>> design/wsfp_parser.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser state machine
// Decodes one frame header per buffer and unmasks its payload, one beat
// per cycle while i_accept is high, producing at most one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wsfp_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic             i_buffer_end,
    output logic                  o_res_valid,
    output wsfp_pkg::t_result     o_res
);
    import wsfp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_header_count, n_header_count;
    logic        r_fin, n_fin;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_masked, n_masked;
    logic [63:0] r_length, n_length;
    logic [31:0] r_mask_key, n_mask_key;
    logic [63:0] r_payload_index, n_payload_index;

    logic        do_len;
    logic        do_hdr;
    logic        incomplete;
    logic        empty;
    logic        last;
    logic [6:0]  code;
    logic [7:0]  key_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_FIRST;
            r_header_count  <= '0;
            r_fin           <= 1'b0;
            r_opcode        <= '0;
            r_masked        <= 1'b0;
            r_length        <= '0;
            r_mask_key      <= '0;
            r_payload_index <= '0;
        end else begin
            r_phase         <= n_phase;
            r_header_count  <= n_header_count;
            r_fin           <= n_fin;
            r_opcode        <= n_opcode;
            r_masked        <= n_masked;
            r_length        <= n_length;
            r_mask_key      <= n_mask_key;
            r_payload_index <= n_payload_index;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_header_count  = r_header_count;
        n_fin           = r_fin;
        n_opcode        = r_opcode;
        n_masked        = r_masked;
        n_length        = r_length;
        n_mask_key      = r_mask_key;
        n_payload_index = r_payload_index;
        do_len          = 1'b0;
        do_hdr          = 1'b0;
        incomplete      = 1'b0;
        empty           = 1'b0;
        last            = 1'b0;
        code            = i_rx_byte[6:0];
        key_byte        = 8'h00;
        o_res_valid     = 1'b0;
        o_res           = '0;
        o_res.kind      = KIND_HEADER;

        if (i_accept) begin
            case (r_phase)
                PH_FIRST: begin
                    n_fin           = i_rx_byte[7];
                    n_opcode        = i_rx_byte[3:0];
                    n_masked        = 1'b0;
                    n_length        = '0;
                    n_mask_key      = '0;
                    n_payload_index = '0;
                    n_header_count  = '0;
                    if (i_buffer_end) begin
                        incomplete = 1'b1;
                    end else if (!opcode_valid(i_rx_byte[3:0])) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.frame_last = 1'b1;
                        n_phase          = PH_DONE;
                    end else begin
                        n_phase = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    n_masked = i_rx_byte[7];
                    n_length = '0;
                    if (code inside {LEN_CODE_16, LEN_CODE_64}) begin
                        n_header_count = (code == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
                        n_phase        = PH_EXTLEN;
                        incomplete     = i_buffer_end;
                    end else begin
                        n_length = {57'd0, code};
                        do_len   = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    n_length       = {r_length[55:0], i_rx_byte};
                    n_header_count = r_header_count - 4'd1;
                    if (n_header_count == 4'd0) begin
                        do_len = 1'b1;
                    end else begin
                        incomplete = i_buffer_end;
                    end
                end
                PH_MASK: begin
                    n_mask_key     = {r_mask_key[23:0], i_rx_byte};
                    n_header_count = r_header_count - 4'd1;
                    if (n_header_count == 4'd0) begin
                        do_hdr = 1'b1;
                    end else begin
                        incomplete = i_buffer_end;
                    end
                end
                PH_PAYLOAD: begin
                    case (r_payload_index[1:0])
                        2'd0:    key_byte = r_mask_key[31:24];
                        2'd1:    key_byte = r_mask_key[23:16];
                        2'd2:    key_byte = r_mask_key[15:8];
                        default: key_byte = r_mask_key[7:0];
                    endcase
                    if (!r_masked) begin
                        key_byte = 8'h00;
                    end
                    n_payload_index    = r_payload_index + 64'd1;
                    last               = (n_payload_index == r_length);
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_PAYLOAD;
                    o_res.body_length  = r_length;
                    o_res.payload_byte = i_rx_byte ^ key_byte;
                    o_res.frame_last   = last | i_buffer_end;
                    o_res.short_buffer = i_buffer_end & ~last;
                    if (last) begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase

            if (do_len) begin
                if (n_masked) begin
                    n_phase        = PH_MASK;
                    n_header_count = MASK_KEY_BYTES;
                    incomplete     = i_buffer_end;
                end else begin
                    do_hdr = 1'b1;
                end
            end

            if (do_hdr) begin
                empty              = (n_length == 64'd0);
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_HEADER;
                o_res.body_length  = n_length;
                o_res.frame_last   = empty | i_buffer_end;
                o_res.short_buffer = i_buffer_end & ~empty;
                n_phase            = empty ? PH_DONE : PH_PAYLOAD;
            end

            if (incomplete) begin
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_INCOMPLETE;
                o_res.frame_last   = 1'b1;
                o_res.short_buffer = 1'b1;
            end

            o_res.fin    = n_fin;
            o_res.opcode = n_opcode;
            o_res.masked = n_masked;

            if (i_buffer_end) begin
                n_phase         = PH_FIRST;
                n_header_count  = '0;
                n_fin           = 1'b0;
                n_opcode        = '0;
                n_masked        = 1'b0;
                n_length        = '0;
                n_mask_key      = '0;
                n_payload_index = '0;
            end
        end
    end

    `ASSERT_IMPLIES(a_extlen_count, i_clk, i_rst_n, r_phase == PH_EXTLEN, r_header_count != 4'd0)
    `ASSERT_IMPLIES(a_mask_needs_bit, i_clk, i_rst_n, r_phase == PH_MASK, r_masked)
    `ASSERT_IMPLIES(a_payload_open, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_payload_index != r_length)

endmodule

`default_nettype wire

>>> design/websocket_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser unit
// Parses one WebSocket frame per received buffer and unmasks its payload.
// ----------------------------------------------------------------------------
// The input channel carries one buffer byte per beat, with i_buffer_end set
// on the buffer's last byte. Each buffer holds one frame. The output channel
// carries a header result, then one result per payload byte, or an error or
// incomplete result; other header bytes before the last produce no result.
// Bytes after a complete frame or an error produce nothing until the buffer
// ends, which returns the parser to the first header byte.
// An input beat is taken every cycle while o_in_stall is low. Its result,
// if any, passes from the combinational parser update into the result
// register, or into the skid register while the receiver stalls.
// The output stage has a result register and one skid register, so a beat
// is still accepted in the cycle the receiver first stalls; o_in_stall rises
// only once the skid register holds a result.
// Synchronous reset returns the parser to the first header byte and empties
// both output registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module websocket_frame_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_buffer_end,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic             o_fin,
    output logic [3:0]       o_opcode,
    output logic             o_masked,
    output logic [63:0]      o_body_length,
    output logic [7:0]       o_payload_byte,
    output logic             o_frame_last,
    output logic             o_short_buffer
);
    import wsfp_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    logic    out_load;

    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid & ~r_skid_valid;
    assign out_load   = ~r_out_valid | ~i_out_stall;

    wsfp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_rx_byte    (i_rx_byte),
        .i_buffer_end (i_buffer_end),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid  <= r_skid_valid | res_valid;
            r_skid_valid <= 1'b0;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_fin          = r_out.fin;
    assign o_opcode       = r_out.opcode;
    assign o_masked       = r_out.masked;
    assign o_body_length  = r_out.body_length;
    assign o_payload_byte = r_out.payload_byte;
    assign o_frame_last   = r_out.frame_last;
    assign o_short_buffer = r_out.short_buffer;

    `ASSERT_IMPLIES(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_NEXT(a_skid_held, i_clk, i_rst_n, r_skid_valid && i_out_stall, r_skid_valid)
    `ASSERT_IMPLIES(a_short_is_last, i_clk, i_rst_n, r_out_valid && r_out.short_buffer, r_out.frame_last)
    `ASSERT_IMPLIES(a_error_is_last, i_clk, i_rst_n, r_out_valid && r_out.kind == KIND_ERROR, r_out.frame_last)

endmodule

`default_nettype wire
